FILE: rtl/bit_vector_logic_shift_unit_core_macros.svh
// assertion macros shared by the bit vector logic and shift unit checker
`ifndef BIT_VECTOR_LOGIC_SHIFT_UNIT_CORE_MACROS_SVH
`define BIT_VECTOR_LOGIC_SHIFT_UNIT_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BVLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bvls: same-cycle property violated");

// consequent must hold from the cycle after the antecedent
`define BVLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bvls: next-cycle property violated");

`endif

FILE: rtl/bvls_pkg.sv
// types and constants of the bit vector logic and shift unit
`timescale 1ns / 1ps

package bvls_pkg;

  // widest supported vector
  localparam int unsigned MAX_BITS = 64;
  localparam int unsigned WIDTH_W  = $clog2(MAX_BITS + 1);
  localparam int unsigned POS_W    = $clog2(MAX_BITS);

  // vector_size reset value
  localparam logic [6:0] VECTOR_SIZE_RESET = 7'd64;

  // operation codes
  localparam logic [4:0] KIND_INV   = 5'd0;
  localparam logic [4:0] KIND_AND   = 5'd1;
  localparam logic [4:0] KIND_OR    = 5'd2;
  localparam logic [4:0] KIND_XOR   = 5'd3;
  localparam logic [4:0] KIND_NAND  = 5'd4;
  localparam logic [4:0] KIND_NOR   = 5'd5;
  localparam logic [4:0] KIND_XNOR  = 5'd6;
  localparam logic [4:0] KIND_SHL   = 5'd7;
  localparam logic [4:0] KIND_SHR   = 5'd8;
  localparam logic [4:0] KIND_ROTL  = 5'd9;
  localparam logic [4:0] KIND_ROTR  = 5'd10;
  localparam logic [4:0] KIND_ANDR  = 5'd11;
  localparam logic [4:0] KIND_ORR   = 5'd12;
  localparam logic [4:0] KIND_XORR  = 5'd13;
  localparam logic [4:0] KIND_FIRST = 5'd14;
  localparam logic [4:0] KIND_LAST  = 5'd15;
  localparam logic [4:0] KIND_EQ    = 5'd16;
  localparam logic [4:0] KIND_LT    = 5'd17;

  // command transfer payload
  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] lhs_vector;
    logic [63:0] rhs_vector;
    logic [7:0]  distance;
  } cmd_t;

  // result transfer payload
  typedef struct packed {
    logic [63:0] result_vector;
    logic        flag;
    logic        bit_found;
    logic [5:0]  bit_position;
  } res_t;

endpackage

FILE: rtl/bit_vector_logic_shift_unit_core.sv
// top level of the bit vector logic and shift unit
//
// usage:
//   command channel: drive cmd_i and raise start; the command transfers at
//   a rising edge where start is high and busy is low. busy stays low, so a
//   new command may transfer in every cycle.
//   result channel: result_valid_o is high for exactly one cycle with res_o
//   holding the result; the receiver takes it in that cycle.
//   config: APB-style port, vector_size at byte address 0 (bits 6:0), read
//   back on prdata; write it only while no command is in flight.
// pipeline: the command passes the stage 1 registers (operand masking and upper
//   rotate modulo steps), the stage 2 registers (lower modulo steps) and,
//   after the operation, the output register that drives result_valid_o.
// throughput: one command per cycle, set by the fully pipelined datapath.
// reset: rst_ni low clears all pipeline valid bits and sets vector_size
//   to 64; no result appears until a command transfers after reset.
// stall: the receiver cannot hold results off, so the pipeline never stalls.
`timescale 1ns / 1ps

module bit_vector_logic_shift_unit_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  // command channel
  input  logic            start,
  output logic            busy,
  input  bvls_pkg::cmd_t  cmd_i,
  // result channel
  output logic            result_valid_o,
  output bvls_pkg::res_t  res_o,
  // config port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import bvls_pkg::*;

  // config register
  logic [6:0] vector_size_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {25'd0, vector_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_size_q <= VECTOR_SIZE_RESET;
    end else if (cfg_wr) begin
      vector_size_q <= pwdata[6:0];
    end
  end

  // stage 1: active width, masking, upper modulo steps
  logic                 accept;
  logic [WIDTH_W-1:0]   width_d;
  logic [MAX_BITS-1:0]  mask_d;
  logic [7:0]           rem_hi_d;

  assign accept = start && !busy;

  always_comb begin
    if (vector_size_q == 7'd0) begin
      width_d = WIDTH_W'(1);
    end else if (vector_size_q > 7'(MAX_BITS)) begin
      width_d = WIDTH_W'(MAX_BITS);
    end else begin
      width_d = WIDTH_W'(vector_size_q);
    end
  end

  assign mask_d = (width_d >= WIDTH_W'(MAX_BITS)) ? '1
                : ((MAX_BITS'(1) << width_d) - MAX_BITS'(1));

  always_comb begin
    rem_hi_d = 8'd0;
    for (int i = 7; i >= 4; i--) begin
      rem_hi_d = {rem_hi_d[6:0], cmd_i.distance[i]};
      if (rem_hi_d >= 8'(width_d)) begin
        rem_hi_d = rem_hi_d - 8'(width_d);
      end
    end
  end

  logic                s1_valid_q;
  logic [4:0]          s1_kind_q;
  logic [63:0]         s1_a_q;
  logic [63:0]         s1_b_q;
  logic [7:0]          s1_dist_q;
  logic [WIDTH_W-1:0]  s1_width_q;
  logic [MAX_BITS-1:0] s1_mask_q;
  logic [6:0]          s1_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= cmd_i.kind;
      s1_a_q     <= cmd_i.lhs_vector & 64'(mask_d);
      s1_b_q     <= cmd_i.rhs_vector & 64'(mask_d);
      s1_dist_q  <= cmd_i.distance;
      s1_width_q <= width_d;
      s1_mask_q  <= mask_d;
      s1_rem_q   <= rem_hi_d[6:0];
    end
  end

  // stage 2: lower modulo steps give the rotate amount
  logic [7:0] rem_lo_d;

  always_comb begin
    rem_lo_d = {1'b0, s1_rem_q};
    for (int i = 3; i >= 0; i--) begin
      rem_lo_d = {rem_lo_d[6:0], s1_dist_q[i]};
      if (rem_lo_d >= 8'(s1_width_q)) begin
        rem_lo_d = rem_lo_d - 8'(s1_width_q);
      end
    end
  end

  logic                s2_valid_q;
  logic [4:0]          s2_kind_q;
  logic [63:0]         s2_a_q;
  logic [63:0]         s2_b_q;
  logic [7:0]          s2_dist_q;
  logic [WIDTH_W-1:0]  s2_width_q;
  logic [MAX_BITS-1:0] s2_mask_q;
  logic [WIDTH_W-1:0]  s2_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_kind_q  <= s1_kind_q;
      s2_a_q     <= s1_a_q;
      s2_b_q     <= s1_b_q;
      s2_dist_q  <= s1_dist_q;
      s2_width_q <= s1_width_q;
      s2_mask_q  <= s1_mask_q;
      s2_rot_q   <= WIDTH_W'(rem_lo_d);
    end
  end

  // stage 3: operation select
  logic [63:0]        vec_d;
  logic               flag_d;
  logic               found_d;
  logic [POS_W-1:0]   first_pos;
  logic [POS_W-1:0]   last_pos;
  logic [5:0]         pos_d;
  logic               too_far;
  logic [WIDTH_W-1:0] rot_back;
  logic [63:0]        rotl_val;
  logic [63:0]        rotr_val;

  assign too_far  = s2_dist_q >= 8'(s2_width_q);
  assign rot_back = s2_width_q - s2_rot_q;
  assign rotl_val = (s2_rot_q == '0) ? s2_a_q
                  : ((s2_a_q << s2_rot_q) | (s2_a_q >> rot_back));
  assign rotr_val = (s2_rot_q == '0) ? s2_a_q
                  : ((s2_a_q >> s2_rot_q) | (s2_a_q << rot_back));

  // lowest and highest set bit
  always_comb begin
    first_pos = '0;
    last_pos  = '0;
    for (int i = MAX_BITS - 1; i >= 0; i--) begin
      if (s2_a_q[i]) begin
        first_pos = POS_W'(i);
      end
    end
    for (int i = 0; i < MAX_BITS; i++) begin
      if (s2_a_q[i]) begin
        last_pos = POS_W'(i);
      end
    end
  end

  always_comb begin
    vec_d   = 64'd0;
    flag_d  = 1'b0;
    found_d = 1'b0;
    pos_d   = 6'd0;
    case (s2_kind_q)
      KIND_INV:   vec_d = ~s2_a_q;
      KIND_AND:   vec_d = s2_a_q & s2_b_q;
      KIND_OR:    vec_d = s2_a_q | s2_b_q;
      KIND_XOR:   vec_d = s2_a_q ^ s2_b_q;
      KIND_NAND:  vec_d = ~(s2_a_q & s2_b_q);
      KIND_NOR:   vec_d = ~(s2_a_q | s2_b_q);
      KIND_XNOR:  vec_d = ~(s2_a_q ^ s2_b_q);
      KIND_SHL:   vec_d = too_far ? 64'd0 : (s2_a_q << s2_dist_q);
      KIND_SHR:   vec_d = too_far ? 64'd0 : (s2_a_q >> s2_dist_q);
      KIND_ROTL:  vec_d = rotl_val;
      KIND_ROTR:  vec_d = rotr_val;
      KIND_ANDR:  flag_d = (s2_a_q == 64'(s2_mask_q));
      KIND_ORR:   flag_d = |s2_a_q;
      KIND_XORR:  flag_d = ^s2_a_q;
      KIND_FIRST: begin
        found_d = |s2_a_q;
        pos_d   = 6'(first_pos);
      end
      KIND_LAST: begin
        found_d = |s2_a_q;
        pos_d   = 6'(last_pos);
      end
      KIND_EQ:    flag_d = (s2_a_q == s2_b_q);
      KIND_LT:    flag_d = (s2_a_q < s2_b_q);
      default:    vec_d = 64'd0;
    endcase
  end

  // output register
  logic result_valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      res_q.result_vector <= vec_d & 64'(s2_mask_q);
      res_q.flag          <= flag_d;
      res_q.bit_found     <= found_d;
      res_q.bit_position  <= pos_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign res_o          = res_q;

endmodule

FILE: rtl/bvls_checker.sv
// port-level checker for the bit vector logic and shift unit, with its bind
`timescale 1ns / 1ps
`include "bit_vector_logic_shift_unit_core_macros.svh"

module bvls_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input bvls_pkg::cmd_t  cmd_i,
  input logic            result_valid_o,
  input bvls_pkg::res_t  res_o
);
  import bvls_pkg::*;

  // every command transfer yields a result once it has passed the pipeline
  `BVLS_ASSERT_NEXT(a_cmd_gives_result, clk_i, rst_ni, start && !busy, ##2 result_valid_o)

  // no result without an earlier command transfer
  `BVLS_ASSERT_SAME(a_result_has_cmd, clk_i, rst_ni, result_valid_o, $past(start && !busy, 3))

  // flag, reduce, find and undefined kinds leave the vector result at zero
  `BVLS_ASSERT_SAME(a_vec_zero, clk_i, rst_ni, result_valid_o && ($past(cmd_i.kind, 3) >= KIND_ANDR), res_o.result_vector == 64'd0)

  // only find kinds report a bit position
  `BVLS_ASSERT_SAME(a_find_only, clk_i, rst_ni, result_valid_o && ($past(cmd_i.kind, 3) != KIND_FIRST) && ($past(cmd_i.kind, 3) != KIND_LAST), !res_o.bit_found && (res_o.bit_position == 6'd0))

endmodule

bind bit_vector_logic_shift_unit_core bvls_checker u_bvls_checker (.*);

FILE: verif/bvls_result_checker.sv
// result checker of the bit vector logic and shift unit: predicts and compares every result
`timescale 1ns / 1ps

module bvls_result_checker #(
  parameter logic [2:0] VS_ADDR = 3'd0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // command channel
  input  logic            start_i,
  input  logic            busy_i,
  input  bvls_pkg::cmd_t  cmd_i,
  // result channel
  input  logic            result_valid_i,
  input  bvls_pkg::res_t  res_i,
  // config port
  input  logic            psel_i,
  input  logic            penable_i,
  input  logic            pwrite_i,
  input  logic [2:0]      paddr_i,
  input  logic [31:0]     pwdata_i,
  input  logic [31:0]     prdata_i,
  input  logic            pready_i,
  // status toward the testbench top
  output int unsigned     fail_count_o,
  output int unsigned     inflight_o,
  output int unsigned     checked_o
);

  import bvls_pkg::*;

  // one predicted result with the command that caused it
  typedef struct {
    cmd_t cmd;
    res_t res;
  } pending_t;

  pending_t    pending_results[$];
  logic [6:0]  size_q;
  int unsigned mismatch_cnt;
  int unsigned checked_cnt;

  // expected result of one command under the given vector_size value
  function automatic res_t compute_bvls_result(cmd_t c, logic [6:0] size);
    int unsigned w;
    int unsigned d;
    int unsigned r;
    int          i;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] v;
    res_t        o;
    // clamp the width to 1..64
    if (size == 7'd0) begin
      w = 1;
    end else if (size > 7'd64) begin
      w = 64;
    end else begin
      w = 32'(size);
    end
    m = (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    a = c.lhs_vector & m;
    b = c.rhs_vector & m;
    d = 32'(c.distance);
    v = '0;
    o = '0;
    case (c.kind)
      KIND_INV:  v = ~a;
      KIND_AND:  v = a & b;
      KIND_OR:   v = a | b;
      KIND_XOR:  v = a ^ b;
      KIND_NAND: v = ~(a & b);
      KIND_NOR:  v = ~(a | b);
      KIND_XNOR: v = ~(a ^ b);
      KIND_SHL:  v = (d >= w) ? 64'd0 : (a << d);
      KIND_SHR:  v = (d >= w) ? 64'd0 : (a >> d);
      KIND_ROTL: begin
        r = d % w;
        v = (r == 0) ? a : ((a << r) | (a >> (w - r)));
      end
      KIND_ROTR: begin
        r = d % w;
        v = (r == 0) ? a : ((a >> r) | (a << (w - r)));
      end
      KIND_ANDR: o.flag = (a == m);
      KIND_ORR:  o.flag = (a != 64'd0);
      KIND_XORR: o.flag = ^a;
      KIND_FIRST: begin
        if (a != 64'd0) begin
          o.bit_found = 1'b1;
          for (i = 63; i >= 0; i--) begin
            if (a[i]) o.bit_position = i[5:0];
          end
        end
      end
      KIND_LAST: begin
        if (a != 64'd0) begin
          o.bit_found = 1'b1;
          for (i = 0; i < 64; i++) begin
            if (a[i]) o.bit_position = i[5:0];
          end
        end
      end
      KIND_EQ:   o.flag = (a == b);
      KIND_LT:   o.flag = (a < b);
      default: begin
      end
    endcase
    o.result_vector = v & m;
    return o;
  endfunction

  // count a failure, report only the first few
  function automatic bit report_allowed();
    mismatch_cnt++;
    return (mismatch_cnt <= 10);
  endfunction

  // watch all channels, compare at result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    pending_t head;
    pending_t item;
    if (!rst_ni) begin
      pending_results.delete();
      size_q       = VECTOR_SIZE_RESET;
      mismatch_cnt = 0;
      checked_cnt  = 0;
      inflight_o   <= 0;
    end else begin
      // result transfer against the oldest prediction
      if (result_valid_i) begin
        if (pending_results.size() == 0) begin
          if (report_allowed())
            $display("%0t: result with nothing pending: vec %h flag %b found %b pos %0d",
                     $realtime, res_i.result_vector, res_i.flag, res_i.bit_found,
                     res_i.bit_position);
        end else begin
          head = pending_results.pop_front();
          checked_cnt++;
          if (res_i.result_vector !== head.res.result_vector ||
              res_i.flag !== head.res.flag ||
              res_i.bit_found !== head.res.bit_found ||
              res_i.bit_position !== head.res.bit_position) begin
            if (report_allowed()) begin
              $display("%0t: mismatch kind %0d lhs %h rhs %h dist %0d",
                       $realtime, head.cmd.kind, head.cmd.lhs_vector,
                       head.cmd.rhs_vector, head.cmd.distance);
              $display("  expected vec %h flag %b found %b pos %0d",
                       head.res.result_vector, head.res.flag, head.res.bit_found,
                       head.res.bit_position);
              $display("  actual   vec %h flag %b found %b pos %0d",
                       res_i.result_vector, res_i.flag, res_i.bit_found,
                       res_i.bit_position);
            end
          end
        end
      end
      // command transfer
      if (start_i && !busy_i) begin
        item.cmd = cmd_i;
        item.res = compute_bvls_result(cmd_i, size_q);
        pending_results.push_back(item);
      end
      // register read back
      if (psel_i && penable_i && !pwrite_i && pready_i && paddr_i == VS_ADDR) begin
        if (prdata_i[6:0] !== size_q) begin
          if (report_allowed())
            $display("%0t: vector_size read back %0d, expected %0d",
                     $realtime, prdata_i[6:0], size_q);
        end
      end
      // register write, other addresses are ignored
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == VS_ADDR) begin
        size_q = pwdata_i[6:0];
      end
      inflight_o <= pending_results.size();
    end
  end

  assign fail_count_o = mismatch_cnt;
  assign checked_o    = checked_cnt;

endmodule

FILE: verif/tb_top.sv
// testbench top of the bit vector logic and shift unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_top;

  import bvls_pkg::*;

  localparam logic [2:0] VS_ADDR    = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned PHASE_ITEMS = 128;
  localparam int unsigned QUIET_AFTER = 1220;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        result_valid;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_cnt;
  int unsigned inflight;
  int unsigned checked_cnt;
  int unsigned sent_cnt;
  int unsigned setting_cnt;
  int unsigned stall_cnt;
  int unsigned eff_width;
  bit          quiet;

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  bit_vector_logic_shift_unit_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .result_valid_o (result_valid),
    .res_o          (res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  bvls_result_checker #(
    .VS_ADDR (VS_ADDR)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .result_valid_i (result_valid),
    .res_i          (res),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .fail_count_o   (fail_cnt),
    .inflight_o     (inflight),
    .checked_o      (checked_cnt)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid || (psel && penable)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cnt);
      $display("** bit_vector_logic_shift_unit_core: FAILED **");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic cmd_t mk_cmd(logic [4:0] kind, logic [63:0] lhs, logic [63:0] rhs,
                                  logic [7:0] dist_val);
    cmd_t c;
    c.kind       = kind;
    c.lhs_vector = lhs;
    c.rhs_vector = rhs;
    c.distance   = dist_val;
    return c;
  endfunction

  // operand with a mix of corner patterns and plain random bits
  function automatic logic [63:0] rand_vector();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = {64{1'b1}};
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~(64'd1 << $urandom_range(0, 63));
      4: v = 64'($urandom_range(0, 15));
      5: v = ({$urandom, $urandom} << $urandom_range(0, 63));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic cmd_t rand_cmd(int unsigned w);
    cmd_t c;
    c.kind = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(18, 31))
                                          : 5'($urandom_range(0, 17));
    c.lhs_vector = rand_vector();
    // equal operands now and then so that eq hits
    case ($urandom_range(0, 5))
      0: c.rhs_vector = c.lhs_vector;
      1: c.rhs_vector = c.lhs_vector ^ (64'd1 << $urandom_range(0, 63));
      default: c.rhs_vector = rand_vector();
    endcase
    c.distance = $urandom_range(0, 1) ? 8'($urandom_range(0, w + 1))
                                      : 8'($urandom_range(0, 255));
    return c;
  endfunction

  // one command transfer, optionally after an idle burst
  task automatic send_item(cmd_t c);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
    sent_cnt++;
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (inflight != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new width setting with random upper bits in the write data
  task automatic set_width(logic [6:0] value);
    drain();
    apb_access(1'b1, VS_ADDR, ($urandom & 32'hFFFF_FF80) | {25'd0, value});
    apb_access(1'b0, VS_ADDR, 32'd0);
    if (value == 7'd0) begin
      eff_width = 1;
    end else if (value > 7'd64) begin
      eff_width = 64;
    end else begin
      eff_width = 32'(value);
    end
    setting_cnt++;
  endtask

  // stimulus
  initial begin
    logic [6:0] widths [11];
    int unsigned p;
    int unsigned k;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd         = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    stall_cnt   = 0;
    sent_cnt    = 0;
    setting_cnt = 1;
    eff_width   = 64;
    quiet       = 1'b0;
    widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd32, 7'd63, 7'd2, 7'd17,
               7'($urandom_range(1, 64)), 7'd64};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value read back
    apb_access(1'b0, VS_ADDR, 32'd0);

    // directed: every operation at the extremes, full width
    send_item(mk_cmd(KIND_INV,  64'd0, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_AND,  {64{1'b1}}, {64{1'b1}}, 8'd0));
    send_item(mk_cmd(KIND_OR,   64'd0, {64{1'b1}}, 8'd255));
    send_item(mk_cmd(KIND_XOR,  {64{1'b1}}, 64'h5555_5555_5555_5555, 8'd0));
    send_item(mk_cmd(KIND_NAND, {64{1'b1}}, {64{1'b1}}, 8'd0));
    send_item(mk_cmd(KIND_NOR,  64'd0, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_XNOR, 64'hF0F0_F0F0_F0F0_F0F0, 64'd0, 8'd0));
    // shifts up to and past the width
    send_item(mk_cmd(KIND_SHL,  {64{1'b1}}, 64'd0, 8'd63));
    send_item(mk_cmd(KIND_SHL,  {64{1'b1}}, 64'd0, 8'd64));
    send_item(mk_cmd(KIND_SHR,  {64{1'b1}}, 64'd0, 8'd255));
    // rotate by zero copies, larger distances wrap
    send_item(mk_cmd(KIND_ROTL, 64'h8000_0000_0000_0001, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_ROTL, 64'h8000_0000_0000_0001, 64'd0, 8'd65));
    send_item(mk_cmd(KIND_ROTR, 64'h0000_0000_0000_0003, 64'd0, 8'd1));
    send_item(mk_cmd(KIND_ROTR, 64'h1234_5678_9ABC_DEF0, 64'd0, 8'd128));
    // reductions
    send_item(mk_cmd(KIND_ANDR, {64{1'b1}}, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_ORR,  64'd0, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_XORR, 64'h0000_0000_0000_0007, 64'd0, 8'd0));
    // bit search with none and with the edge bits
    send_item(mk_cmd(KIND_FIRST, 64'd0, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_FIRST, 64'h8000_0000_0000_0000, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_LAST,  64'd1, 64'd0, 8'd0));
    send_item(mk_cmd(KIND_LAST,  {64{1'b1}}, 64'd0, 8'd0));
    // compares
    send_item(mk_cmd(KIND_EQ, 64'hDEAD_BEEF_0000_FFFF, 64'hDEAD_BEEF_0000_FFFF, 8'd0));
    send_item(mk_cmd(KIND_LT, {64{1'b1}}, 64'd0, 8'd0));
    // undefined kinds
    send_item(mk_cmd(5'd18, {64{1'b1}}, {64{1'b1}}, 8'd255));
    send_item(mk_cmd(5'd31, {64{1'b1}}, {64{1'b1}}, 8'd255));

    // random phases, one per width setting
    for (p = 0; p < 11; p++) begin
      if (p != 0) set_width(widths[p]);
      // writes to an unmapped register must leave vector_size alone
      if (p == 3 || p == 7) begin
        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, VS_ADDR, 32'd0);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        quiet = (sent_cnt >= QUIET_AFTER);
        if (!quiet && $urandom_range(0, 59) == 0) drain();
        send_item(rand_cmd(eff_width));
      end
    end

    // wait out the pipeline
    drain();
    repeat (8) @(posedge clk_i);

    $display("run covered %0d commands over %0d vector_size settings, %0d results compared",
             sent_cnt, setting_cnt, checked_cnt);
    $display("settings included widths 0, 1, 64 and 127, all 18 operations and undefined kinds");
    if (inflight != 0)
      $display("%0d predicted results never arrived", inflight);
    if (fail_cnt == 0 && inflight == 0) begin
      $display("** bit_vector_logic_shift_unit_core: PASSED **");
    end else begin
      $display("** bit_vector_logic_shift_unit_core: FAILED **");
    end
    $finish;
  end

endmodule
